@@ design/lfp_pkg.sv @@
// shared types and constants for the link fragment planner
`timescale 1ns / 1ps
`default_nettype none

package lfp_pkg;

    // overhead of a single whole frame and of each fragment, in bytes
    localparam int SingleOverhead = (1 + 9) + (1 + 1 + 8) + (1 + 9);
    localparam int FragOverhead   = (1 + 9) + (1 + 1 + 8) + (1 + 1 + 8) + (1 + 1 + 8) + (1 + 9);

    // largest fragment limit the block supports
    localparam int MaxFrags = 64;

    // field widths
    localparam int ByteW  = 16;
    localparam int IndexW = 6;
    localparam int CountW = 7;
    localparam int OpW    = ByteW + 1;

    // configuration register indexes
    localparam logic CFG_MTU       = 1'b0;
    localparam logic CFG_MAX_FRAGS = 1'b1;

    // result kinds
    typedef enum logic [1:0] {
        STAT_WHOLE      = 2'd0,
        STAT_FRAG       = 2'd1,
        STAT_DROP_MTU   = 2'd2,
        STAT_DROP_COUNT = 2'd3
    } status_t;

    // operations of the shared subtractor
    typedef enum logic [2:0] {
        OP_FIT,
        OP_HDR,
        OP_CHUNK,
        OP_FIRST,
        OP_COUNT,
        OP_LEN
    } alu_op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIT,
        ST_HDR,
        ST_CHUNK,
        ST_FIRST,
        ST_COUNT,
        ST_EMIT,
        ST_SINGLE
    } state_t;

    // operands the subtractor may pick from
    typedef struct packed {
        logic [ByteW-1:0] mtu;
        logic [ByteW-1:0] total;
        logic [ByteW-1:0] payload;
        logic [ByteW-1:0] header;
        logic [ByteW-1:0] room;
        logic [ByteW-1:0] rest;
        logic [ByteW-1:0] chunk;
        logic [ByteW-1:0] left;
    } alu_in_t;

    // subtractor result
    typedef struct packed {
        logic [OpW-1:0] diff;
        logic           borrow;
        logic           zero;
    } alu_res_t;

endpackage

`default_nettype wire

@@ design/lfp_alu.sv @@
// shared operand select and subtractor of the fragment planner
`timescale 1ns / 1ps
`default_nettype none

module lfp_alu
    import lfp_pkg::*;
(
    input  alu_op_t  op,
    input  alu_in_t  opnd,
    output alu_res_t res
);

    logic [OpW-1:0] a;
    logic [OpW-1:0] b;
    logic [OpW:0]   full;

    // operand select
    always_comb begin
        a = {1'b0, opnd.mtu};
        b = '0;
        case (op)
            OP_FIT: begin
                a = {1'b0, opnd.mtu};
                b = {1'b0, opnd.total} + OpW'(SingleOverhead);
            end
            OP_HDR: begin
                a = {1'b0, opnd.mtu};
                b = {1'b0, opnd.header} + OpW'(FragOverhead);
            end
            OP_CHUNK: begin
                a = {1'b0, opnd.mtu};
                b = OpW'(FragOverhead);
            end
            OP_FIRST: begin
                a = {1'b0, opnd.payload};
                b = {1'b0, opnd.room};
            end
            OP_COUNT: begin
                a = {1'b0, opnd.rest};
                b = {1'b0, opnd.chunk};
            end
            OP_LEN: begin
                a = {1'b0, opnd.left};
                b = {1'b0, opnd.chunk};
            end
            default: begin
                a = {1'b0, opnd.mtu};
                b = '0;
            end
        endcase
    end

    // one subtract with borrow out
    assign full       = {1'b0, a} - {1'b0, b};
    assign res.diff   = full[OpW-1:0];
    assign res.borrow = full[OpW];
    assign res.zero   = (full[OpW-1:0] == '0);

endmodule

`default_nettype wire

@@ design/link_fragment_planner_top.sv @@
// link fragment planner: plans how each packet is cut into link fragments
//
// Usage:
//  - one input beat on s_* describes a packet (wire size, payload, extra headers)
//  - results leave on m_*: one beat for a whole frame or a drop, otherwise one
//    beat per fragment in order; m_tlast marks the final beat of a packet
//  - cfg_* writes mtu (index 0) and max_fragments (index 1); cfg_ready is
//    high only while the sequencer is idle
// Timing:
//  - s_tready is high only while the sequencer is idle; one packet at a time
//  - a whole frame is found by the fit check and a drop by the header check;
//    either is sent as one beat from the single state, then the sequencer idles
//  - a fragmented packet of N fragments runs four setup passes, N counting
//    passes through the shared subtractor and N beats while the receiver
//    takes them, before the sequencer is idle for the next input beat
// Reset: aresetn clears the sequencer and output valid, mtu returns to 1500
//  and max_fragments to 64
// Stall: the output register holds its beat while m_tready is low; the next
//  packet may be taken and planned but waits before its first result
`timescale 1ns / 1ps
`default_nettype none

module link_fragment_planner_top
    import lfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // total_wire_bytes, payload_bytes, header_bytes
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // frag_index, frag_count, offset, length, zero pad
    output logic [1:0]       m_tuser,   // status
    output logic             m_tlast
);

    // configuration registers
    logic [ByteW-1:0]  mtu_reg;
    logic [CountW-1:0] max_frags_reg;
    logic [CountW-1:0] limit;

    // sequencer and datapath registers
    state_t            state_reg, state_next;
    logic [ByteW-1:0]  total_reg, total_next;
    logic [ByteW-1:0]  payload_reg, payload_next;
    logic [ByteW-1:0]  header_reg, header_next;
    logic [ByteW-1:0]  room_reg, room_next;
    logic [ByteW-1:0]  chunk_reg, chunk_next;
    logic [ByteW-1:0]  rest_reg, rest_next;
    logic [ByteW-1:0]  left_reg, left_next;
    logic [ByteW-1:0]  first_reg, first_next;
    logic [ByteW-1:0]  off_reg, off_next;
    logic [IndexW-1:0] idx_reg, idx_next;
    logic [CountW-1:0] cnt_reg, cnt_next;
    status_t           stat_reg, stat_next;

    // output register
    logic              ovalid_reg, ovalid_next;
    status_t           ostat_reg, ostat_next;
    logic [IndexW-1:0] oidx_reg, oidx_next;
    logic [CountW-1:0] ocnt_reg, ocnt_next;
    logic [ByteW-1:0]  ooff_reg, ooff_next;
    logic [ByteW-1:0]  olen_reg, olen_next;
    logic              olast_reg, olast_next;

    // shared subtractor
    alu_op_t  alu_op;
    alu_in_t  alu_in;
    alu_res_t alu_res;

    logic             in_beat;
    logic             out_free;
    logic [ByteW-1:0] frag_len;
    logic             frag_last;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign out_free  = !ovalid_reg || m_tready;

    // limit saturates at the supported fragment count
    assign limit = (max_frags_reg > CountW'(MaxFrags)) ? CountW'(MaxFrags) : max_frags_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtu_reg       <= ByteW'(1500);
            max_frags_reg <= CountW'(64);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MTU:       mtu_reg       <= cfg_data;
                CFG_MAX_FRAGS: max_frags_reg <= cfg_data[CountW-1:0];
                default:       mtu_reg       <= mtu_reg;
            endcase
        end
    end

    // subtractor operands
    always_comb begin
        alu_in.mtu     = mtu_reg;
        alu_in.total   = total_reg;
        alu_in.payload = payload_reg;
        alu_in.header  = header_reg;
        alu_in.room    = room_reg;
        alu_in.rest    = rest_reg;
        alu_in.chunk   = chunk_reg;
        alu_in.left    = left_reg;
    end

    always_comb begin
        case (state_reg)
            ST_FIT:   alu_op = OP_FIT;
            ST_HDR:   alu_op = OP_HDR;
            ST_CHUNK: alu_op = OP_CHUNK;
            ST_FIRST: alu_op = OP_FIRST;
            ST_COUNT: alu_op = OP_COUNT;
            ST_EMIT:  alu_op = OP_LEN;
            default:  alu_op = OP_FIT;
        endcase
    end

    lfp_alu u_alu (
        .op   (alu_op),
        .opnd (alu_in),
        .res  (alu_res)
    );

    // length and last flag of the fragment being sent
    assign frag_len  = (idx_reg == '0) ? first_reg :
                       (alu_res.borrow ? left_reg : chunk_reg);
    assign frag_last = (({1'b0, idx_reg} + CountW'(1)) == cnt_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    state_next = ST_FIT;
                end
            end
            ST_FIT: begin
                state_next = alu_res.borrow ? ST_HDR : ST_SINGLE;
            end
            ST_HDR: begin
                state_next = (alu_res.borrow || alu_res.zero) ? ST_SINGLE : ST_CHUNK;
            end
            ST_CHUNK: begin
                state_next = ST_FIRST;
            end
            ST_FIRST: begin
                state_next = ST_COUNT;
            end
            ST_COUNT: begin
                if (cnt_reg > limit) begin
                    state_next = ST_SINGLE;
                end else if (rest_reg == '0) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && frag_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SINGLE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output register updates
    always_comb begin
        total_next   = total_reg;
        payload_next = payload_reg;
        header_next  = header_reg;
        room_next    = room_reg;
        chunk_next   = chunk_reg;
        rest_next    = rest_reg;
        left_next    = left_reg;
        first_next   = first_reg;
        off_next     = off_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        stat_next    = stat_reg;

        ovalid_next = ovalid_reg && !m_tready;
        ostat_next  = ostat_reg;
        oidx_next   = oidx_reg;
        ocnt_next   = ocnt_reg;
        ooff_next   = ooff_reg;
        olen_next   = olen_reg;
        olast_next  = olast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    total_next   = s_tdata[15:0];
                    payload_next = s_tdata[31:16];
                    header_next  = s_tdata[47:32];
                    off_next     = '0;
                    idx_next     = '0;
                    cnt_next     = CountW'(1);
                end
            end
            // whole frame fits the mtu
            ST_FIT: begin
                if (!alu_res.borrow) begin
                    stat_next  = STAT_WHOLE;
                    cnt_next   = CountW'(1);
                    first_next = payload_reg;
                end
            end
            // room left for payload in the first fragment
            ST_HDR: begin
                room_next = alu_res.diff[ByteW-1:0];
                if (alu_res.borrow || alu_res.zero) begin
                    stat_next  = STAT_DROP_MTU;
                    cnt_next   = '0;
                    first_next = '0;
                end
            end
            ST_CHUNK: begin
                chunk_next = alu_res.diff[ByteW-1:0];
            end
            // first fragment takes what fits, the rest goes to later ones
            ST_FIRST: begin
                if (alu_res.borrow) begin
                    first_next = payload_reg;
                    rest_next  = '0;
                    left_next  = '0;
                end else begin
                    first_next = room_reg;
                    rest_next  = alu_res.diff[ByteW-1:0];
                    left_next  = alu_res.diff[ByteW-1:0];
                end
            end
            // count fragments one chunk at a time, give up past the limit
            ST_COUNT: begin
                if (cnt_reg > limit) begin
                    stat_next  = STAT_DROP_COUNT;
                    cnt_next   = '0;
                    first_next = '0;
                end else if (rest_reg != '0) begin
                    rest_next = (alu_res.borrow || alu_res.zero) ? '0 :
                                alu_res.diff[ByteW-1:0];
                    cnt_next  = cnt_reg + CountW'(1);
                end
            end
            // one fragment beat per free output slot
            ST_EMIT: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    ostat_next  = STAT_FRAG;
                    oidx_next   = idx_reg;
                    ocnt_next   = cnt_reg;
                    ooff_next   = off_reg;
                    olen_next   = frag_len;
                    olast_next  = frag_last;
                    off_next    = off_reg + frag_len;
                    idx_next    = idx_reg + IndexW'(1);
                    if (idx_reg != '0) begin
                        left_next = alu_res.borrow ? '0 : alu_res.diff[ByteW-1:0];
                    end
                end
            end
            // whole frame or drop, one beat
            ST_SINGLE: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    ostat_next  = stat_reg;
                    oidx_next   = '0;
                    ocnt_next   = cnt_reg;
                    ooff_next   = '0;
                    olen_next   = first_reg;
                    olast_next  = 1'b1;
                end
            end
            default: begin
                ovalid_next = ovalid_reg && !m_tready;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        total_reg   <= total_next;
        payload_reg <= payload_next;
        header_reg  <= header_next;
        room_reg    <= room_next;
        chunk_reg   <= chunk_next;
        rest_reg    <= rest_next;
        left_reg    <= left_next;
        first_reg   <= first_next;
        off_reg     <= off_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        stat_reg    <= stat_next;
        ostat_reg   <= ostat_next;
        oidx_reg    <= oidx_next;
        ocnt_reg    <= ocnt_next;
        ooff_reg    <= ooff_next;
        olen_reg    <= olen_next;
        olast_reg   <= olast_next;
    end

    // result port
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {3'b000, olen_reg, ooff_reg, ocnt_reg, oidx_reg};
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

@@ test/frag_plan_checker.sv @@
// checker for the link fragment planner: predicts the fragment plan of each packet and compares
`timescale 1ns / 1ps

module frag_plan_checker
    import lfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // total_wire_bytes, payload_bytes, header_bytes
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,   // frag_index, frag_count, offset, length, zero pad
    input  wire logic [1:0]  m_tuser,   // status
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending
);

    // one planned result beat
    typedef struct packed {
        status_t           status;
        logic [IndexW-1:0] index;
        logic [CountW-1:0] count;
        logic [ByteW-1:0]  offset;
        logic [ByteW-1:0]  length;
        logic              last;
    } frag_beat_t;

    frag_beat_t expected_frags[$];
    int         link_mtu;
    int         frag_limit_reg;
    int         errs;

    function automatic void push_beat(status_t st, int idx, int cnt, int off, int len, bit fin);
        frag_beat_t b;
        b.status = st;
        b.index  = idx[IndexW-1:0];
        b.count  = cnt[CountW-1:0];
        b.offset = off[ByteW-1:0];
        b.length = len[ByteW-1:0];
        b.last   = fin;
        expected_frags.push_back(b);
    endfunction

    // work out the whole plan of one packet for the current mtu and limit
    function automatic void plan_packet(int total, int payload, int header);
        int first, chunk, rest, count, limit, off, len;
        if (total + SingleOverhead <= link_mtu) begin
            push_beat(STAT_WHOLE, 0, 1, 0, payload, 1'b1);
        end else if (FragOverhead + header + 1 > link_mtu) begin
            push_beat(STAT_DROP_MTU, 0, 0, 0, 0, 1'b1);
        end else begin
            first = link_mtu - header - FragOverhead;
            if (payload < first)
                first = payload;
            chunk = link_mtu - FragOverhead;
            rest  = payload - first;
            count = 1 + rest / chunk + (((rest % chunk) != 0) ? 1 : 0);
            limit = (frag_limit_reg > MaxFrags) ? MaxFrags : frag_limit_reg;
            if (count > limit) begin
                push_beat(STAT_DROP_COUNT, 0, 0, 0, 0, 1'b1);
            end else begin
                off = 0;
                for (int i = 0; i < count; i++) begin
                    len = (i == 0) ? first : chunk;
                    if (len > payload - off)
                        len = payload - off;
                    push_beat(STAT_FRAG, i, count, off, len, (i + 1) == count);
                    off += len;
                end
            end
        end
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            errs++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // watch all three channels on each edge
    always @(posedge aclk) begin
        frag_beat_t b;
        if (!aresetn) begin
            link_mtu       = 1500;
            frag_limit_reg = 64;
            expected_frags.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MTU)
                    link_mtu = int'(cfg_data);
                else if (cfg_index == CFG_MAX_FRAGS)
                    frag_limit_reg = int'(cfg_data[6:0]);
            end
            // packet descriptor beat
            if (s_tvalid && s_tready)
                plan_packet(int'(s_tdata[15:0]), int'(s_tdata[31:16]), int'(s_tdata[47:32]));
            // result beat
            if (m_tvalid && m_tready) begin
                if (expected_frags.size() == 0) begin
                    errs++;
                    $display("%0t ns: result beat with nothing expected, status %0d tdata %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    b = expected_frags.pop_front();
                    check_field("status", int'(b.status), int'(m_tuser));
                    check_field("frag_index", int'(b.index), int'(m_tdata[5:0]));
                    check_field("frag_count", int'(b.count), int'(m_tdata[12:6]));
                    check_field("offset", int'(b.offset), int'(m_tdata[28:13]));
                    check_field("length", int'(b.length), int'(m_tdata[44:29]));
                    check_field("last", int'(b.last), int'(m_tlast));
                    check_field("pad", 0, int'(m_tdata[47:45]));
                end
            end
        end
        pending    <= expected_frags.size();
        fail_count <= errs;
    end

endmodule

@@ test/testbench.sv @@
// top of the link fragment planner testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import lfp_pkg::*;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;    // total_wire_bytes, payload_bytes, header_bytes
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;           // frag_index, frag_count, offset, length, zero pad
    logic [1:0]  m_tuser;           // status
    logic        m_tlast;

    int fail_count;
    int pending;

    // settings the stimulus shapes its packets for, and the idle limits per side
    int cur_mtu  = 1500;
    int cur_maxf = 64;
    int tx_max   = 13;
    int rx_max   = 13;
    int rx_hold  = 0;

    link_fragment_planner_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    frag_plan_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #60_000_000;
        $display("testbench: errors");
        $finish;
    end

    // result side: random back-pressure per beat, one long hold when asked
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge aclk);
                rx_hold = 0;
            end
            stall = $urandom_range(0, rx_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // one descriptor beat after a random gap; valid stays up for a back-to-back beat
    task automatic send_packet(input logic [15:0] total, input logic [15:0] payload,
                               input logic [15:0] header);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {header, payload, total};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait until every planned beat has come out
    task automatic drain_results;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // random packet aimed mostly at the fragment path of the current setting
    task automatic make_packet(output logic [15:0] total, output logic [15:0] payload,
                               output logic [15:0] header);
        int kind, lim, chunk, room, k, p;
        kind    = $urandom_range(0, 99);
        lim     = (cur_maxf > MaxFrags) ? MaxFrags : cur_maxf;
        chunk   = cur_mtu - FragOverhead;
        total   = 16'($urandom);
        payload = 16'($urandom);
        header  = 16'($urandom);
        if (kind < 15) begin
            // fits as a whole frame
            if (cur_mtu >= SingleOverhead)
                total = 16'($urandom_range(0, cur_mtu - SingleOverhead));
        end else if (kind < 95) begin
            // too big for a whole frame
            total = 16'($urandom_range((cur_mtu >= SingleOverhead) ?
                                       cur_mtu - SingleOverhead + 1 : 0, 65535));
            if (kind < 25) begin
                // headers leave no room for a first fragment
                header = 16'($urandom_range((chunk > 0) ? chunk : 0, 65535));
            end else if (chunk >= 1) begin
                header = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, chunk - 1) :
                              $urandom_range(0, (chunk - 1 < 64) ? chunk - 1 : 64));
                room = chunk - header;
                if (lim == 0) begin
                    p = $urandom_range(0, 3000);
                end else if (kind < 85) begin
                    k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, lim) :
                        $urandom_range(1, (lim < 6) ? lim : 6);
                    p = (k == 1) ? $urandom_range(0, room) :
                        room + (k - 2) * chunk + $urandom_range(1, chunk);
                end else begin
                    // one or two fragments past the limit
                    p = room + ($urandom_range(0, 1) + lim - 1) * chunk + $urandom_range(1, chunk);
                end
                payload = (p > 65535) ? 16'hFFFF : p[15:0];
            end
        end
    endtask

    // new register setting, then n random packets
    task automatic run_phase(input int mtu, input int maxf, input int n, input int tx,
                             input int rx, input int hold);
        logic [15:0] t, p, h;
        drain_results;
        write_reg(CFG_MTU, mtu[15:0]);
        write_reg(CFG_MAX_FRAGS, maxf[15:0]);
        cur_mtu  = mtu & 16'hFFFF;
        cur_maxf = maxf & 7'h7F;
        tx_max   = tx;
        rx_max   = rx;
        rx_hold  = hold;
        repeat (n) begin
            make_packet(t, p, h);
            send_packet(t, p, h);
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setting: whole frame edges, empty payload, exact fits, header limit
        send_packet(16'd0, 16'd0, 16'd0);
        send_packet(16'd1470, 16'hFFFF, 16'hFFFF);
        send_packet(16'd1471, 16'd0, 16'd0);
        send_packet(16'd1471, 16'd1450, 16'd0);
        send_packet(16'd1471, 16'd1451, 16'd0);
        send_packet(16'hFFFF, 16'hFFFF, 16'd0);
        send_packet(16'hFFFF, 16'hFFFF, 16'd1449);
        send_packet(16'd2000, 16'd100, 16'd1450);
        send_packet(16'hFFFF, 16'd0, 16'hFFFF);
        send_packet(16'd1500, 16'd2900, 16'd0);

        // largest mtu, limit above the hardware maximum
        run_phase(65535, 127, 0, 13, 13, 0);
        send_packet(16'd65505, 16'hFFFF, 16'd0);
        send_packet(16'd65506, 16'hFFFF, 16'd0);
        send_packet(16'hFFFF, 16'hFFFF, 16'd65484);

        // one-byte fragments
        run_phase(51, 2, 0, 13, 13, 0);
        send_packet(16'd100, 16'd2, 16'd0);
        send_packet(16'd100, 16'd3, 16'd0);
        send_packet(16'd100, 16'hFFFF, 16'd0);
        send_packet(16'd100, 16'd0, 16'd1);

        // zero mtu: nothing fits
        run_phase(0, 0, 0, 13, 13, 0);
        send_packet(16'd0, 16'd0, 16'd0);

        // zero fragment limit
        run_phase(1500, 0, 0, 13, 13, 0);
        send_packet(16'd2000, 16'd10, 16'd0);
        send_packet(16'd2000, 16'd0, 16'd0);

        // limit of one fragment
        run_phase(1500, 1, 0, 13, 13, 0);
        send_packet(16'd2000, 16'd1450, 16'd0);
        send_packet(16'd2000, 16'd1451, 16'd0);

        // random packets over several settings
        run_phase(1500, 64, 50, 13, 13, 0);
        run_phase(65535, 127, 40, 0, 0, 0);
        run_phase(576, 8, 40, 0, 13, 300);
        run_phase(51, 64, 40, 13, 0, 0);
        run_phase(0, 0, 15, 13, 13, 0);
        run_phase(9000, 16, 40, 0, 13, 0);
        run_phase(1500, 0, 15, 13, 13, 0);
        repeat (3)
            run_phase($urandom_range(51, 4000), $urandom_range(0, 127), 40, 13, 13, 0);

        drain_results;
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
